// ===== rtl/bmsfp_pkg.sv =====
// Shared constants and types for the battery management frame parser.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package bmsfp_pkg;

   localparam logic [7:0] SOF_BYTE    = 8'hDD;
   localparam logic [7:0] FUNC_BYTE   = 8'h03;
   localparam logic [7:0] STATUS_BYTE = 8'h00;
   localparam logic [7:0] END_BYTE    = 8'h77;

   localparam int STORE_DEPTH = 8;
   localparam int STORE_IDX_W = $clog2(STORE_DEPTH);

   typedef logic [7:0] store_type [STORE_DEPTH];

   typedef struct packed {
      logic        frame_valid;
      logic [15:0] voltage_raw;
      logic [15:0] current_raw;
      logic [15:0] remain_capacity;
      logic [15:0] full_capacity;
   } rsp_type;

endpackage

`default_nettype wire

// ===== rtl/bms_frame_parser_core.sv =====
// Battery management frame parser, top level: input word register, parser, result register.
// Depends on bmsfp_pkg and bmsfp_parser.
// An accepted req word is held in the input word register, then parsed into the result register, and shows on rsp.
// Throughput: one word per cycle while rsp_stall is low; every accepted word yields exactly one rsp word.
// Reset (synchronous, active high): both stages empty, parser hunting for a start byte,
// checksum and payload store cleared to zero.
`timescale 1ns / 1ps
`default_nettype none

module bms_frame_parser_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [7:0]  req_rx_byte,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic        rsp_frame_valid,
   output      logic [15:0] rsp_voltage_raw,
   output      logic [15:0] rsp_current_raw,
   output      logic [15:0] rsp_remain_capacity,
   output      logic [15:0] rsp_full_capacity
);
   import bmsfp_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       out_valid_ff, out_valid_in;
   rsp_type    out_ff;
   rsp_type    step_result;
   logic       out_load;
   logic       in_load;

   // Result register frees up when empty or when its word is taken this cycle.
   assign out_load  = !out_valid_ff || !rsp_stall;
   // Advance the held word into the parser whenever the result register can take it.
   assign req_stall = in_valid_ff && !out_load;
   assign in_load   = req_valid && !req_stall;

   assign in_valid_in  = in_load ? 1'b1 : (in_valid_ff && !out_load);
   assign out_valid_in = out_load ? in_valid_ff : out_valid_ff;

   bmsfp_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step_en (in_valid_ff && out_load),
      .rx_byte (in_byte_ff),
      .result  (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers: capture on load, hold otherwise.
   always_ff @(posedge clock) begin
      if (in_load) in_byte_ff <= req_rx_byte;
      if (out_load && in_valid_ff) out_ff <= step_result;
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_frame_valid     = out_ff.frame_valid;
   assign rsp_voltage_raw     = out_ff.voltage_raw;
   assign rsp_current_raw     = out_ff.current_raw;
   assign rsp_remain_capacity = out_ff.remain_capacity;
   assign rsp_full_capacity   = out_ff.full_capacity;

endmodule

`default_nettype wire

// ===== rtl/bmsfp_parser.sv =====
// Frame parser state machine: phase, length, running checksum and payload store.
// Depends on bmsfp_pkg. Result is combinational from current state and the byte.
`timescale 1ns / 1ps
`default_nettype none

module bmsfp_parser (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step_en,
   input  wire logic [7:0]        rx_byte,
   output bmsfp_pkg::rsp_type     result
);
   import bmsfp_pkg::*;

   localparam logic [2:0] PH_HUNT    = 3'd0;
   localparam logic [2:0] PH_FUNC    = 3'd1;
   localparam logic [2:0] PH_STATUS  = 3'd2;
   localparam logic [2:0] PH_LEN     = 3'd3;
   localparam logic [2:0] PH_PAYLOAD = 3'd4;
   localparam logic [2:0] PH_CHK_HI  = 3'd5;
   localparam logic [2:0] PH_CHK_LO  = 3'd6;
   localparam logic [2:0] PH_END     = 3'd7;

   logic [2:0]  phase_ff, phase_in;
   logic [7:0]  length_ff, length_in;
   logic [7:0]  count_ff, count_in;
   logic [15:0] sum_ff, sum_in;
   logic [15:0] check_ff, check_in;
   store_type   store_ff;

   logic        store_we;
   logic        frame_ok;
   logic [7:0]  count_inc;

   assign count_inc = count_ff + 8'd1;

   always_comb begin
      phase_in  = phase_ff;
      length_in = length_ff;
      count_in  = count_ff;
      sum_in    = sum_ff;
      check_in  = check_ff;
      store_we  = 1'b0;
      frame_ok  = 1'b0;
      unique case (phase_ff)
         PH_HUNT: begin
            if (rx_byte == SOF_BYTE) phase_in = PH_FUNC;
         end
         PH_FUNC: begin
            phase_in = (rx_byte == FUNC_BYTE) ? PH_STATUS : PH_HUNT;
         end
         PH_STATUS: begin
            if (rx_byte == STATUS_BYTE) begin
               sum_in   = {8'd0, rx_byte};
               phase_in = PH_LEN;
            end else begin
               phase_in = PH_HUNT;
            end
         end
         PH_LEN: begin
            if (rx_byte != 8'd0) begin
               length_in = rx_byte;
               count_in  = 8'd0;
               sum_in    = sum_ff + {8'd0, rx_byte};
               phase_in  = PH_PAYLOAD;
            end else begin
               phase_in = PH_HUNT;
            end
         end
         PH_PAYLOAD: begin
            if (count_ff < length_ff) begin
               store_we = (count_ff < 8'(STORE_DEPTH));
               sum_in   = sum_ff + {8'd0, rx_byte};
               count_in = count_inc;
            end
            if (count_in >= length_ff) phase_in = PH_CHK_HI;
         end
         PH_CHK_HI: begin
            check_in = {rx_byte, 8'd0};
            phase_in = PH_CHK_LO;
         end
         PH_CHK_LO: begin
            check_in = {check_ff[15:8], rx_byte};
            phase_in = PH_END;
         end
         PH_END: begin
            frame_ok = (rx_byte == END_BYTE) && ((16'd0 - sum_ff) == check_ff);
            phase_in = PH_HUNT;
         end
         default: phase_in = PH_HUNT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HUNT;
         length_ff <= '0;
         count_ff  <= '0;
         sum_ff    <= '0;
         check_ff  <= '0;
         for (int i = 0; i < STORE_DEPTH; i++) store_ff[i] <= '0;
      end else if (step_en) begin
         phase_ff  <= phase_in;
         length_ff <= length_in;
         count_ff  <= count_in;
         sum_ff    <= sum_in;
         check_ff  <= check_in;
         if (store_we) store_ff[count_ff[STORE_IDX_W-1:0]] <= rx_byte;
      end
   end

   // Fields read zero unless the frame checks out.
   always_comb begin
      result.frame_valid     = frame_ok;
      result.voltage_raw     = frame_ok ? {store_ff[0], store_ff[1]} : 16'd0;
      result.current_raw     = frame_ok ? {store_ff[2], store_ff[3]} : 16'd0;
      result.remain_capacity = frame_ok ? {store_ff[4], store_ff[5]} : 16'd0;
      result.full_capacity   = frame_ok ? {store_ff[6], store_ff[7]} : 16'd0;
   end

endmodule

`default_nettype wire

// ===== tb/bmsfp_tb_pkg.sv =====
// Scoreboard for the battery management frame parser: tracks the parse state and
// holds the result words that each accepted byte should produce.
// Depends on bmsfp_pkg for the framing bytes, store depth and result word type.
`timescale 1ns / 1ps

package bmsfp_tb_pkg;
   import bmsfp_pkg::*;

   typedef enum logic [2:0] {
      HUNT_START,
      GET_FUNC,
      GET_STATUS,
      GET_LENGTH,
      GET_PAYLOAD,
      GET_CHECK_HI,
      GET_CHECK_LO,
      GET_END
   } parse_phase_type;

   class frame_scoreboard;
      parse_phase_type phase;
      logic [7:0]   frame_len;
      logic [7:0]   byte_count;
      logic [15:0]  sum;
      logic [15:0]  rx_check;
      logic [7:0]   kept [STORE_DEPTH];
      rsp_type      awaited [$];
      int unsigned  errors;
      int unsigned  frames_ok;
      int unsigned  words_checked;

      function new();
         phase = HUNT_START;
         frame_len = '0;
         byte_count = '0;
         sum = '0;
         rx_check = '0;
         foreach (kept[i]) kept[i] = '0;
         errors = 0;
         frames_ok = 0;
         words_checked = 0;
      endfunction

      function int outstanding();
         return awaited.size();
      endfunction

      // Advance the parse state by one byte and queue the word it yields.
      function void note_byte(logic [7:0] b);
         rsp_type r;
         logic    ok;
         r = '0;
         ok = 1'b0;
         case (phase)
            HUNT_START: begin
               if (b == SOF_BYTE) phase = GET_FUNC;
            end
            GET_FUNC: begin
               phase = (b == FUNC_BYTE) ? GET_STATUS : HUNT_START;
            end
            GET_STATUS: begin
               if (b == STATUS_BYTE) begin
                  sum = {8'h00, b};
                  phase = GET_LENGTH;
               end else begin
                  phase = HUNT_START;
               end
            end
            GET_LENGTH: begin
               if (b != 8'h00) begin
                  frame_len = b;
                  byte_count = '0;
                  sum = sum + {8'h00, b};
                  phase = GET_PAYLOAD;
               end else begin
                  phase = HUNT_START;
               end
            end
            GET_PAYLOAD: begin
               if (byte_count < frame_len) begin
                  if (byte_count < STORE_DEPTH) kept[byte_count[STORE_IDX_W-1:0]] = b;
                  sum = sum + {8'h00, b};
                  byte_count = byte_count + 8'd1;
               end
               if (byte_count >= frame_len) phase = GET_CHECK_HI;
            end
            GET_CHECK_HI: begin
               rx_check = {b, 8'h00};
               phase = GET_CHECK_LO;
            end
            GET_CHECK_LO: begin
               rx_check = rx_check | {8'h00, b};
               phase = GET_END;
            end
            default: begin
               if (b == END_BYTE && rx_check == (~sum + 16'd1)) ok = 1'b1;
               phase = HUNT_START;
            end
         endcase
         if (ok) begin
            r.frame_valid     = 1'b1;
            r.voltage_raw     = {kept[0], kept[1]};
            r.current_raw     = {kept[2], kept[3]};
            r.remain_capacity = {kept[4], kept[5]};
            r.full_capacity   = {kept[6], kept[7]};
            frames_ok++;
         end
         awaited.push_back(r);
      endfunction

      task report_mismatch(string what);
         $display("MISMATCH at %0t: %s", $time, what);
         errors++;
      endtask

      // Compare one delivered word, field by field, with the oldest one queued.
      task check_word(rsp_type got);
         rsp_type want;
         if (awaited.size() == 0) begin
            report_mismatch($sformatf("result word %h with nothing queued", got));
            return;
         end
         want = awaited.pop_front();
         words_checked++;
         if (got.frame_valid !== want.frame_valid)
            report_mismatch($sformatf("frame_valid %b, want %b",
                                      got.frame_valid, want.frame_valid));
         if (got.voltage_raw !== want.voltage_raw)
            report_mismatch($sformatf("voltage_raw %h, want %h",
                                      got.voltage_raw, want.voltage_raw));
         if (got.current_raw !== want.current_raw)
            report_mismatch($sformatf("current_raw %h, want %h",
                                      got.current_raw, want.current_raw));
         if (got.remain_capacity !== want.remain_capacity)
            report_mismatch($sformatf("remain_capacity %h, want %h",
                                      got.remain_capacity, want.remain_capacity));
         if (got.full_capacity !== want.full_capacity)
            report_mismatch($sformatf("full_capacity %h, want %h",
                                      got.full_capacity, want.full_capacity));
      endtask
   endclass

endpackage

// ===== tb/tb_top.sv =====
// Top of the frame parser testbench: clock, reset, byte and result drivers, monitors
// and watchdog. Depends on bmsfp_pkg, bmsfp_tb_pkg and bms_frame_parser_core.
`timescale 1ns / 1ps

module tb_top;
   import bmsfp_pkg::*;
   import bmsfp_tb_pkg::*;

   localparam int RANDOM_BYTES   = 1000;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 10;
   localparam int IDLE_PERCENT   = 32;

   // Ways in which a generated frame is spoilt
   typedef enum int {
      FLAW_NONE,
      FLAW_CHECKSUM,
      FLAW_END,
      FLAW_FUNC,
      FLAW_STATUS,
      FLAW_LENGTH
   } frame_flaw_type;

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_stall   = 1'b0;
   logic        req_stall;
   logic        rsp_valid;
   logic        rsp_frame_valid;
   logic [15:0] rsp_voltage_raw;
   logic [15:0] rsp_current_raw;
   logic [15:0] rsp_remain_capacity;
   logic [15:0] rsp_full_capacity;

   bit              idle_on = 1'b1;
   int unsigned     bytes_sent = 0;
   int unsigned     quiet_cycles = 0;
   logic [7:0]      frame_q [$];
   logic [7:0]      payload_q [$];
   frame_scoreboard sb = new();

   bms_frame_parser_core dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_rx_byte         (req_rx_byte),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_frame_valid     (rsp_frame_valid),
      .rsp_voltage_raw     (rsp_voltage_raw),
      .rsp_current_raw     (rsp_current_raw),
      .rsp_remain_capacity (rsp_remain_capacity),
      .rsp_full_capacity   (rsp_full_capacity)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Monitors: sample both channels at the edge, before any of this edge's updates land
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) sb.note_byte(req_rx_byte);
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_word(rsp_type'({rsp_frame_valid, rsp_voltage_raw, rsp_current_raw,
                                  rsp_remain_capacity, rsp_full_capacity}));
   end

   // Throttle the result side; stall is free to ignore valid
   always @(posedge clock) begin
      rsp_stall <= idle_on && ($urandom_range(99) < IDLE_PERCENT);
   end

   // Watchdog: give up once nothing has moved on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("Watchdog expired after %0d idle cycles, %0d words still due",
                  WATCHDOG_LIMIT, sb.outstanding());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offer one word, with random idle cycles in front, and hold it until taken
   task automatic send_byte(input logic [7:0] b);
      while (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_queue();
      foreach (frame_q[i]) send_byte(frame_q[i]);
      frame_q.delete();
   endtask

   // Drop valid and hold off until every queued result word has come back
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.outstanding() != 0);
   endtask

   function automatic logic [7:0] any_byte_but(input logic [7:0] avoid);
      logic [7:0] x;
      do x = 8'($urandom_range(255)); while (x == avoid);
      return x;
   endfunction

   // Build a frame around payload_q; a header flaw ends the frame at the bad byte
   task automatic queue_frame(input frame_flaw_type flaw);
      logic [15:0] s;
      logic [15:0] chk;
      logic [7:0]  len;
      len = 8'(payload_q.size());
      frame_q.push_back(SOF_BYTE);
      if (flaw == FLAW_FUNC) begin
         frame_q.push_back(any_byte_but(FUNC_BYTE));
         return;
      end
      frame_q.push_back(FUNC_BYTE);
      if (flaw == FLAW_STATUS) begin
         frame_q.push_back(any_byte_but(STATUS_BYTE));
         return;
      end
      frame_q.push_back(STATUS_BYTE);
      if (flaw == FLAW_LENGTH) begin
         frame_q.push_back(8'h00);
         return;
      end
      frame_q.push_back(len);
      s = {8'h00, STATUS_BYTE} + {8'h00, len};
      foreach (payload_q[i]) begin
         frame_q.push_back(payload_q[i]);
         s = s + {8'h00, payload_q[i]};
      end
      chk = ~s + 16'd1;
      if (flaw == FLAW_CHECKSUM) chk = chk ^ 16'($urandom_range(65535, 1));
      frame_q.push_back(chk[15:8]);
      frame_q.push_back(chk[7:0]);
      frame_q.push_back((flaw == FLAW_END) ? any_byte_but(END_BYTE) : END_BYTE);
   endtask

   function automatic int pick_length();
      int r;
      r = $urandom_range(99);
      if (r < 70) return $urandom_range(8, 1);
      if (r < 97) return $urandom_range(20, 9);
      return $urandom_range(255, 21);
   endfunction

   function automatic frame_flaw_type pick_flaw();
      int r;
      r = $urandom_range(99);
      if (r < 65) return FLAW_NONE;
      if (r < 75) return FLAW_CHECKSUM;
      if (r < 83) return FLAW_END;
      if (r < 88) return FLAW_FUNC;
      if (r < 94) return FLAW_STATUS;
      return FLAW_LENGTH;
   endfunction

   initial begin
      int unsigned directed_bytes;
      int          n;
      bit          paused;
      paused = 1'b0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: good short frame of all-ones payload, leaving the rest of the store at zero
      payload_q = '{8'hFF, 8'hFF};
      queue_frame(FLAW_NONE);
      // Start byte where the function byte belongs: must not restart the frame
      frame_q.push_back(SOF_BYTE);
      frame_q.push_back(SOF_BYTE);
      queue_frame(FLAW_STATUS);
      queue_frame(FLAW_LENGTH);
      // One-byte frame of zero with a corrupt end byte
      payload_q = '{8'h00};
      queue_frame(FLAW_END);
      send_queue();
      directed_bytes = bytes_sent;

      // Hold the sender until the directed results are all back
      drain();

      // Random: mostly well-formed frames with random content, some spoilt, some noise
      while (bytes_sent < directed_bytes + RANDOM_BYTES) begin
         // Keep a long stretch in the middle free of idles and stalls
         idle_on = !(bytes_sent >= directed_bytes + 300 && bytes_sent < directed_bytes + 500);
         if ($urandom_range(99) < 12) begin
            n = $urandom_range(6, 1);
            repeat (n) frame_q.push_back(8'($urandom_range(255)));
         end else begin
            payload_q.delete();
            n = pick_length();
            repeat (n) payload_q.push_back(8'($urandom_range(255)));
            queue_frame(pick_flaw());
         end
         send_queue();
         if (!paused && bytes_sent >= directed_bytes + 650) begin
            drain();
            paused = 1'b1;
         end
      end

      idle_on = 1'b1;
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d bytes (%0d directed); %0d result words checked, %0d good frames",
               bytes_sent, directed_bytes, sb.words_checked, sb.frames_ok);
      $display("Frames covered: good, bad checksum, bad end, bad header, noise, long payloads");
      if (sb.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("%0d mismatches", sb.errors);
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
